// File: rtl/sfd_pkg.sv
// Package for the sensor frame deframer: widths, register indexes,
// reset values and frame status codes.
// No dependencies.
package sfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 5;   // frame byte position, 0 while hunting
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned FLD_BYTES = 21;  // frame bytes 1 to 21 feed the result
  localparam int unsigned FLD_IDX_W = 5;
  localparam int unsigned FLD_LAST  = 21;  // highest frame byte that feeds a field
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // register indexes (paddr[2])
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  localparam logic [BYTE_W-1:0] HEAD_RST = 8'd123;
  localparam logic [BYTE_W-1:0] TAIL_RST = 8'd125;

  typedef enum logic [1:0] {
    STAT_GOOD     = 2'd0,
    STAT_BAD_SUM  = 2'd1,
    STAT_BAD_TAIL = 2'd2
  } frm_status_e;

endpackage

// File: rtl/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port,
// read data registered. No dependencies.
module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sensor_frame_deframer_top.sv
// Sensor frame deframer top level: byte hunter, checksum, frame store
// and result unpacking. Depends on sfd_pkg and sfd_ram.
//
// Usage:
//   rx channel (rx_valid_i/rx_ready_o, rx_byte_i) takes one received byte
//   per cycle unless stalled. The block hunts for head_byte, collects
//   FRAME_BYTES bytes, XORs every byte before the tail, and checks the tail.
//   res channel (res_valid_o/res_ready_i) gives one item per completed
//   frame: status, stop flag and ten big-endian signed words.
//   APB port: register 0 head_byte at 0x0, register 1 tail_byte at 0x4.
// Timing:
//   One byte per cycle sustained unless stalled. Data bytes go into a
//   two-bank frame RAM; after the tail byte the completed bank is read
//   back one byte a cycle (single RAM read port) into the result register.
//   The next frame fills the other bank meanwhile.
// Reset: hunting, checksum cleared, no result pending, registers at
//   123 / 125. The frame RAM is not cleared; every byte read is written first.
// Stall: a held result blocks readback of the next frame; a third frame's
//   tail byte then waits (rx_ready_o low) until a bank is free.
module sensor_frame_deframer_top #(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // byte input
  input  logic                             rx_valid_i,
  output logic                             rx_ready_o,
  input  logic [sfd_pkg::BYTE_W-1:0]       rx_byte_i,
  // result output
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic [1:0]                       frame_status_o,
  output logic [sfd_pkg::BYTE_W-1:0]       halt_flag_o,
  output logic signed [sfd_pkg::WORD_W-1:0] vel_x_o,
  output logic signed [sfd_pkg::WORD_W-1:0] vel_y_o,
  output logic signed [sfd_pkg::WORD_W-1:0] vel_yaw_o,
  output logic signed [sfd_pkg::WORD_W-1:0] accel_x_o,
  output logic signed [sfd_pkg::WORD_W-1:0] accel_y_o,
  output logic signed [sfd_pkg::WORD_W-1:0] accel_z_o,
  output logic signed [sfd_pkg::WORD_W-1:0] gyro_x_o,
  output logic signed [sfd_pkg::WORD_W-1:0] gyro_y_o,
  output logic signed [sfd_pkg::WORD_W-1:0] gyro_z_o,
  output logic signed [sfd_pkg::WORD_W-1:0] battery_mv_o,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfd_pkg::PADDR_W-1:0]      paddr,
  input  logic [sfd_pkg::PDATA_W-1:0]      pwdata,
  output logic [sfd_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  import sfd_pkg::*;

  localparam int unsigned DATA_BYTES = FRAME_BYTES - 2;
  localparam int unsigned IDX_W      = $clog2(DATA_BYTES);
  localparam int unsigned RAM_DEPTH  = 2 * (2 ** IDX_W);
  localparam int unsigned RAM_AW     = IDX_W + 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] SUM_POS  = POS_W'(FRAME_BYTES - 2);
  // highest frame byte read back: short frames stop early, long ones at 21
  localparam logic [POS_W-1:0] LAST_RD  =
      POS_W'((FRAME_BYTES > FLD_LAST + 3) ? FLD_LAST : FRAME_BYTES - 3);

  // configuration
  logic [BYTE_W-1:0] head_q, tail_q;

  // receive state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              wr_bank_q, wr_bank_d;

  // pending frame and readback
  logic              pend_q, pend_d;
  frm_status_e       pend_stat_q, pend_stat_d;
  logic              drn_q, drn_d;     // readback in progress
  logic              iss_q, iss_d;     // reads still to issue
  logic [POS_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [POS_W-1:0]  rd_tag_q, rd_tag_d;
  logic              drn_start, drn_done;

  // result register
  logic              out_valid_q, out_valid_d;
  frm_status_e       out_stat_q, out_stat_d;
  logic [BYTE_W-1:0] fld_q [FLD_BYTES];

  // RAM ports
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic rx_fire, res_fire, tail_fire;
  logic [FLD_IDX_W-1:0] fld_sel;

  assign rx_ready_o = !(pend_q && (pos_q == LAST_POS));
  assign rx_fire    = rx_valid_i && rx_ready_o;
  assign res_fire   = out_valid_q && res_ready_i;
  assign tail_fire  = rx_fire && (pos_q == LAST_POS);

  // APB register file
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (paddr[2])
      REG_HEAD: prdata[BYTE_W-1:0] = head_q;
      REG_TAIL: prdata[BYTE_W-1:0] = tail_q;
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RST;
      tail_q <= TAIL_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_HEAD: head_q <= pwdata[BYTE_W-1:0];
        REG_TAIL: tail_q <= pwdata[BYTE_W-1:0];
        default:  head_q <= head_q;
      endcase
    end
  end

  // byte hunter, position counter and running checksum
  always_comb begin
    pos_d       = pos_q;
    xor_d       = xor_q;
    wr_bank_d   = wr_bank_q;
    pend_stat_d = pend_stat_q;
    ram_we      = 1'b0;
    if (rx_fire) begin
      if (pos_q == '0) begin
        if (rx_byte_i == head_q) begin
          pos_d  = POS_W'(1);
          xor_d  = rx_byte_i;
          ram_we = 1'b1;
        end
      end else if (pos_q < SUM_POS) begin
        pos_d  = pos_q + POS_W'(1);
        xor_d  = xor_q ^ rx_byte_i;
        ram_we = 1'b1;
      end else if (pos_q == SUM_POS) begin
        pos_d = pos_q + POS_W'(1);
        xor_d = xor_q ^ rx_byte_i;
      end else begin
        // tail byte: wrong tail outranks a bad checksum
        pos_d     = '0;
        xor_d     = '0;
        wr_bank_d = !wr_bank_q;
        if (rx_byte_i != tail_q) begin
          pend_stat_d = STAT_BAD_TAIL;
        end else if (xor_q != '0) begin
          pend_stat_d = STAT_BAD_SUM;
        end else begin
          pend_stat_d = STAT_GOOD;
        end
      end
    end
  end

  assign ram_waddr = {wr_bank_q, pos_q[IDX_W-1:0]};

  // readback of the completed bank into the result register; the
  // collecting frame writes the other bank, so no forwarding is needed
  assign drn_start = pend_q && !drn_q && !out_valid_q;
  assign drn_done  = rd_vld_q && (rd_tag_q == LAST_RD);
  assign ram_re    = iss_q;
  assign ram_raddr = {!wr_bank_q, rd_idx_q[IDX_W-1:0]};

  always_comb begin
    pend_d      = pend_q;
    drn_d       = drn_q;
    iss_d       = iss_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = iss_q;
    rd_tag_d    = rd_idx_q;
    out_valid_d = out_valid_q;
    out_stat_d  = out_stat_q;
    if (tail_fire) begin
      pend_d = 1'b1;
    end
    if (drn_start) begin
      drn_d    = 1'b1;
      iss_d    = 1'b1;
      rd_idx_d = POS_W'(1);
    end
    if (iss_q) begin
      if (rd_idx_q == LAST_RD) begin
        iss_d = 1'b0;
      end else begin
        rd_idx_d = rd_idx_q + POS_W'(1);
      end
    end
    if (res_fire) begin
      out_valid_d = 1'b0;
    end
    if (drn_done) begin
      pend_d      = 1'b0;
      drn_d       = 1'b0;
      out_valid_d = 1'b1;
      out_stat_d  = pend_stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      xor_q       <= '0;
      wr_bank_q   <= 1'b0;
      pend_q      <= 1'b0;
      pend_stat_q <= STAT_GOOD;
      drn_q       <= 1'b0;
      iss_q       <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      rd_tag_q    <= '0;
      out_valid_q <= 1'b0;
      out_stat_q  <= STAT_GOOD;
    end else begin
      pos_q       <= pos_d;
      xor_q       <= xor_d;
      wr_bank_q   <= wr_bank_d;
      pend_q      <= pend_d;
      pend_stat_q <= pend_stat_d;
      drn_q       <= drn_d;
      iss_q       <= iss_d;
      rd_idx_q    <= rd_idx_d;
      rd_vld_q    <= rd_vld_d;
      rd_tag_q    <= rd_tag_d;
      out_valid_q <= out_valid_d;
      out_stat_q  <= out_stat_d;
    end
  end

  // result bytes: cleared at readback start so missing bytes read as zero
  assign fld_sel = FLD_IDX_W'(rd_tag_q - POS_W'(1));

  always_ff @(posedge clk_i) begin
    if (drn_start) begin
      for (int i = 0; i < FLD_BYTES; i++) begin
        fld_q[i] <= '0;
      end
    end else if (rd_vld_q) begin
      fld_q[fld_sel] <= ram_rdata;
    end
  end

  sfd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result unpacking, big-endian words
  assign res_valid_o    = out_valid_q;
  assign frame_status_o = out_stat_q;
  assign halt_flag_o    = fld_q[0];
  assign vel_x_o        = {fld_q[1],  fld_q[2]};
  assign vel_y_o        = {fld_q[3],  fld_q[4]};
  assign vel_yaw_o      = {fld_q[5],  fld_q[6]};
  assign accel_x_o      = {fld_q[7],  fld_q[8]};
  assign accel_y_o      = {fld_q[9],  fld_q[10]};
  assign accel_z_o      = {fld_q[11], fld_q[12]};
  assign gyro_x_o       = {fld_q[13], fld_q[14]};
  assign gyro_y_o       = {fld_q[15], fld_q[16]};
  assign gyro_z_o       = {fld_q[17], fld_q[18]};
  assign battery_mv_o   = {fld_q[19], fld_q[20]};

`ifndef SYNTHESIS
  // checksum is clear whenever the hunter is idle
  a_xor_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (xor_q == '0))
    else $error("running checksum not clear while hunting");

  // readback never overwrites a result still on offer
  a_drain_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drn_q || rd_vld_q) |-> !out_valid_q)
    else $error("readback active while result held");

  // a completed frame is always queued for readback
  a_tail_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_fire |=> (pend_q && (pos_q == '0)))
    else $error("completed frame not pending");

  // read tags stay inside the stored byte range
  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((rd_tag_q != '0) && (rd_tag_q <= LAST_RD)))
    else $error("readback tag out of range");

  // position never runs past the tail byte
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("frame position out of range");
`endif

endmodule
